// ----- src/bpc_pkg.sv -----
// shared types, register codes and helpers for the barometric compensation block
package bpc_pkg;

  // configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int COEF_W     = 16;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_C1 = 3'd0;
  localparam logic [2:0] REG_C2 = 3'd1;
  localparam logic [2:0] REG_C3 = 3'd2;
  localparam logic [2:0] REG_C4 = 3'd3;
  localparam logic [2:0] REG_C5 = 3'd4;
  localparam logic [2:0] REG_C6 = 3'd5;

  // field widths
  localparam int RAW_W  = 24;
  localparam int TEMP_W = 18;
  localparam int PRES_W = 32;

  // reference temperature in 0.01 degC
  localparam logic signed [19:0] REF_TEMP = 20'sd2000;

  // factory coefficients as one group
  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } coef_t;

  // clamp corrected temperature to the 18-bit output range
  function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [20:0] v);
    logic signed [TEMP_W-1:0] r;
    if (v > 21'sd131071) begin
      r = 18'sd131071;
    end else if (v < -21'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[TEMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/baro_pressure_compensation_unit.sv -----
// an accepted input transaction passes through all eight register stages to the output transaction
// throughput: one item per cycle unless backpressure stalls; eight register stages with two multiply stages
//   for the first-order and square terms and one for the split pressure product
// backpressure stalls only stages that are full; bubbles collapse
// reset (rst_n, synchronous) clears all stage valid bits and the six coefficients
// top level: configuration registers and compensation pipeline
module baro_pressure_compensation_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [47:0]                         in_tdata,   // pressure_raw[23:0], temp_raw[47:24]
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [55:0]                         out_tdata,  // temp_out[17:0], pressure_out[49:18], zero pad
  output logic                                out_tuser,  // low_temp_applied[0]
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [bpc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  bpc_pkg::coef_t                      coef;
  logic signed [bpc_pkg::TEMP_W-1:0]   temp_out;
  logic signed [bpc_pkg::PRES_W-1:0]   pressure_out;
  logic                                low_temp_applied;

  // coefficient registers
  bpc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .coef        (coef)
  );

  // compensation pipeline
  bpc_pipe u_pipe (
    .clk              (clk),
    .rst_n            (rst_n),
    .coef             (coef),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .pressure_raw     (in_tdata[23:0]),
    .temp_raw         (in_tdata[47:24]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .temp_out         (temp_out),
    .pressure_out     (pressure_out),
    .low_temp_applied (low_temp_applied)
  );

  // result packing
  assign out_tdata = {6'h00, pressure_out, temp_out};
  assign out_tuser = low_temp_applied;

endmodule

// ----- src/bpc_cfg_regs.sv -----
// coefficient register file behind the configuration port
module bpc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bpc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready,
  output bpc_pkg::coef_t                    coef
);

  bpc_pkg::coef_t   coef_r;
  bpc_pkg::coef_t   coef_nxt;
  logic [2:0]       reg_idx;
  logic             wr_en;

  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign coef       = coef_r;

  // write decode, indexes beyond the list are dropped
  always_comb begin
    coef_nxt = coef_r;
    if (wr_en) begin
      case (reg_idx)
        bpc_pkg::REG_C1: coef_nxt.c1 = cfg_pwdata[bpc_pkg::COEF_W-1:0];
        bpc_pkg::REG_C2: coef_nxt.c2 = cfg_pwdata[bpc_pkg::COEF_W-1:0];
        bpc_pkg::REG_C3: coef_nxt.c3 = cfg_pwdata[bpc_pkg::COEF_W-1:0];
        bpc_pkg::REG_C4: coef_nxt.c4 = cfg_pwdata[bpc_pkg::COEF_W-1:0];
        bpc_pkg::REG_C5: coef_nxt.c5 = cfg_pwdata[bpc_pkg::COEF_W-1:0];
        bpc_pkg::REG_C6: coef_nxt.c6 = cfg_pwdata[bpc_pkg::COEF_W-1:0];
        default: coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      bpc_pkg::REG_C1: cfg_prdata = {16'h0000, coef_r.c1};
      bpc_pkg::REG_C2: cfg_prdata = {16'h0000, coef_r.c2};
      bpc_pkg::REG_C3: cfg_prdata = {16'h0000, coef_r.c3};
      bpc_pkg::REG_C4: cfg_prdata = {16'h0000, coef_r.c4};
      bpc_pkg::REG_C5: cfg_prdata = {16'h0000, coef_r.c5};
      bpc_pkg::REG_C6: cfg_prdata = {16'h0000, coef_r.c6};
      default:         cfg_prdata = '0;
    endcase
  end

endmodule

// ----- src/bpc_pipe.sv -----
// eight-stage compensation pipeline with per-stage valid bits and backpressure
module bpc_pipe (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bpc_pkg::coef_t                         coef,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [bpc_pkg::RAW_W-1:0]              pressure_raw,
  input  logic [bpc_pkg::RAW_W-1:0]              temp_raw,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bpc_pkg::TEMP_W-1:0]      temp_out,
  output logic signed [bpc_pkg::PRES_W-1:0]      pressure_out,
  output logic                                   low_temp_applied
);

  localparam int NSTG = 8;

  // stage valid bits and load enables
  logic [NSTG:1] vld_r;
  logic [NSTG:1] vld_nxt;
  logic [NSTG:1] en;

  // stage 1: temperature difference
  logic signed [24:0] dt1_r, dt1_nxt;
  logic [23:0]        d1_1_r;

  // stage 2: first products
  logic signed [41:0] pt2_r, po2_r, ps2_r;
  logic signed [49:0] pd2_r;
  logic [23:0]        d1_2_r;

  // stage 3: first-order terms
  logic signed [18:0] q3_r;
  logic signed [19:0] temp3_r, temp3_nxt;
  logic signed [35:0] off3_r, off3_nxt;
  logic signed [35:0] sens3_r, sens3_nxt;
  logic [18:0]        t2_3_r;
  logic               low3_r;
  logic [23:0]        d1_3_r;

  // stage 4: square of temperature deviation
  logic signed [37:0] aux_full;
  logic [35:0]        aux4_r;
  logic signed [19:0] temp4_r;
  logic signed [35:0] off4_r, sens4_r;
  logic [18:0]        t2_4_r;
  logic               low4_r;
  logic [23:0]        d1_4_r;

  // stage 5: second-order correction
  logic [37:0]                       five_a;
  logic signed [39:0]                offc5_r, offc5_nxt;
  logic signed [39:0]                sensc5_r, sensc5_nxt;
  logic signed [20:0]                tempc;
  logic signed [bpc_pkg::TEMP_W-1:0] temp5_r;
  logic                              low5_r;
  logic [23:0]                       d1_5_r;

  // stage 6: split pressure product
  logic [43:0]                       plo6_r;
  logic signed [44:0]                phi6_r;
  logic signed [39:0]                offc6_r;
  logic signed [bpc_pkg::TEMP_W-1:0] temp6_r;
  logic                              low6_r;

  // stage 7: full pressure product
  logic signed [64:0]                prod7_r;
  logic signed [39:0]                offc7_r;
  logic signed [bpc_pkg::TEMP_W-1:0] temp7_r;
  logic                              low7_r;

  // stage 8: output register
  logic signed [43:0]                ps21;
  logic signed [44:0]                pdiff;
  logic signed [bpc_pkg::PRES_W-1:0] pres8_r;
  logic signed [bpc_pkg::TEMP_W-1:0] temp8_r;
  logic                              low8_r;

  // reference temperature plus the floored first-order deviation
  function automatic logic signed [19:0] REF_TEMP_EXT(input logic [18:0] q);
    return bpc_pkg::REF_TEMP + $signed({q[18], q});
  endfunction

  // load enables ripple back from the output so bubbles collapse
  always_comb begin
    en[NSTG] = !vld_r[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready = en[1];

  // valid bits follow the data
  always_comb begin
    vld_nxt[1] = en[1] ? in_valid : vld_r[1];
    for (int k = 2; k <= NSTG; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1
  assign dt1_nxt = $signed({1'b0, temp_raw}) - $signed({1'b0, coef.c5, 8'h00});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dt1_r  <= dt1_nxt;
      d1_1_r <= pressure_raw;
    end
  end

  // stage 2: four independent multiplies
  always_ff @(posedge clk) begin
    if (en[2]) begin
      pt2_r  <= dt1_r * $signed({1'b0, coef.c6});
      po2_r  <= dt1_r * $signed({1'b0, coef.c4});
      ps2_r  <= dt1_r * $signed({1'b0, coef.c3});
      pd2_r  <= dt1_r * dt1_r;
      d1_2_r <= d1_1_r;
    end
  end

  // stage 3: floor shifts and first-order sums
  assign temp3_nxt = REF_TEMP_EXT(pt2_r[41:23]);
  assign off3_nxt  = $signed({4'h0, coef.c2, 16'h0000})
                   + $signed({po2_r[41], po2_r[41:7]});
  assign sens3_nxt = $signed({5'h00, coef.c1, 15'h0000})
                   + $signed({{2{ps2_r[41]}}, ps2_r[41:8]});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      q3_r    <= pt2_r[41:23];
      temp3_r <= temp3_nxt;
      off3_r  <= off3_nxt;
      sens3_r <= sens3_nxt;
      t2_3_r  <= pd2_r[49:31];
      low3_r  <= pt2_r[41];
      d1_3_r  <= d1_2_r;
    end
  end

  // stage 4: square of (temp - 2000), never exceeds 2^34
  assign aux_full = q3_r * q3_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      aux4_r  <= aux_full[35:0];
      temp4_r <= temp3_r;
      off4_r  <= off3_r;
      sens4_r <= sens3_r;
      t2_4_r  <= t2_3_r;
      low4_r  <= low3_r;
      d1_4_r  <= d1_3_r;
    end
  end

  // stage 5: apply low-temperature correction and clamp temperature
  assign five_a = {aux4_r, 2'b00} + {2'b00, aux4_r};

  always_comb begin
    if (low4_r) begin
      offc5_nxt  = $signed({{4{off4_r[35]}}, off4_r})  - $signed({3'b000, five_a[37:1]});
      sensc5_nxt = $signed({{4{sens4_r[35]}}, sens4_r}) - $signed({4'h0, five_a[37:2]});
      tempc      = $signed({temp4_r[19], temp4_r}) - $signed({2'b00, t2_4_r});
    end else begin
      offc5_nxt  = $signed({{4{off4_r[35]}}, off4_r});
      sensc5_nxt = $signed({{4{sens4_r[35]}}, sens4_r});
      tempc      = $signed({temp4_r[19], temp4_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      offc5_r  <= offc5_nxt;
      sensc5_r <= sensc5_nxt;
      temp5_r  <= bpc_pkg::sat_temp(tempc);
      low5_r   <= low4_r;
      d1_5_r   <= d1_4_r;
    end
  end

  // stage 6: raw pressure times sensitivity as two partial products
  always_ff @(posedge clk) begin
    if (en[6]) begin
      plo6_r  <= d1_5_r * sensc5_r[19:0];
      phi6_r  <= $signed({1'b0, d1_5_r}) * $signed(sensc5_r[39:20]);
      offc6_r <= offc5_r;
      temp6_r <= temp5_r;
      low6_r  <= low5_r;
    end
  end

  // stage 7: recombine partial products
  always_ff @(posedge clk) begin
    if (en[7]) begin
      prod7_r <= $signed({phi6_r, 20'h00000}) + $signed({21'd0, plo6_r});
      offc7_r <= offc6_r;
      temp7_r <= temp6_r;
      low7_r  <= low6_r;
    end
  end

  // stage 8: subtract offset and floor shift; result always fits 30 bits
  assign ps21  = prod7_r[64:21];
  assign pdiff = $signed({ps21[43], ps21}) - $signed({{5{offc7_r[39]}}, offc7_r});

  always_ff @(posedge clk) begin
    if (en[8]) begin
      pres8_r <= $signed({{2{pdiff[44]}}, pdiff[44:15]});
      temp8_r <= temp7_r;
      low8_r  <= low7_r;
    end
  end

  assign out_valid        = vld_r[NSTG];
  assign temp_out         = temp8_r;
  assign pressure_out     = pres8_r;
  assign low_temp_applied = low8_r;

  // a stalled stage keeps its item
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (($past(vld_r & ~en) & ~vld_r) == '0))
    else $error("stalled pipeline stage lost its item");

  // input is held off only when every stage is occupied
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("input blocked with an empty stage");

  // correction flag agrees with the delivered temperature
  a_low_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (low_temp_applied == (temp_out < 18'sd2000)))
    else $error("low-temperature flag disagrees with temperature");

endmodule
